// File: rtl/core/lcg_rejection_word_generator_defines.svh
// ---------------------------------------------------------------------------
// LCG rejection word generator - assertion macros
// Concurrent assertion wrappers used by the controller; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef LCG_REJECTION_WORD_GENERATOR_DEFINES_SVH
`define LCG_REJECTION_WORD_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// lbl: assertion label, prop: property body, msg: error text
`define LRWG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cond must never be true
`define LRWG_ASSERT_NEVER(lbl, cond, msg) \
  `LRWG_ASSERT(lbl, !(cond), msg)
`else
`define LRWG_ASSERT(lbl, prop, msg)
`define LRWG_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: rtl/core/lcgrw_pkg.sv
// ---------------------------------------------------------------------------
// LCG rejection word generator - package
// Constants, command codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package lcgrw_pkg;

  localparam int unsigned StateW = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned RawW   = 15;

  localparam logic [StateW-1:0] LcgMul   = 32'd1103515245;
  localparam logic [StateW-1:0] LcgInc   = 32'd12345;
  localparam logic [StateW-1:0] LcgReset = 32'd1;
  localparam logic [9:0]        ByteMod  = 10'd257;

  typedef enum logic [1:0] {
    CMD_SEED = 2'd0,
    CMD_BYTE = 2'd1,
    CMD_WORD = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } fsm_t;

  // controller -> datapath
  typedef struct packed {
    logic load_seed;
    logic step;       // commit one generator step
    logic shift;      // accepted byte goes into the word accumulator
    logic out_load;   // capture the finished result
    logic word_mode;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic byte_ok;    // current candidate draw passes the mod-257 test
  } dp_status_t;

endpackage

// File: rtl/core/lcgrw_datapath.sv
// ---------------------------------------------------------------------------
// LCG rejection word generator - datapath
// LCG state, one step per cycle if enabled, mod-257 rejection, word packing.
// ---------------------------------------------------------------------------
module lcgrw_datapath import lcgrw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd_i,
  input  logic [StateW-1:0] seed_i,
  output dp_status_t        status_o,
  output logic [StateW-1:0] value_o
);

  logic [StateW-1:0] lcg_r, lcg_nxt;
  logic [StateW-1:0] step_val;
  logic [RawW-1:0]   raw;
  logic [9:0]        diff;
  logic [8:0]        rem;
  logic [ByteW-1:0]  byte_val;
  logic [StateW-1:0] acc_r, acc_nxt;
  logic [StateW-1:0] out_r, out_nxt;
  logic [StateW-1:0] result;

  assign step_val = lcg_r * LcgMul + LcgInc;
  assign raw      = step_val[30:16];

  // 256 == -1 mod 257, so raw mod 257 = low byte - high part, wrapped once
  always_comb begin
    diff = {2'b00, raw[7:0]} - {3'b000, raw[14:8]};
    if (diff[9]) begin
      diff = diff + ByteMod;
    end
    rem = diff[8:0];
  end

  assign byte_val         = rem[ByteW-1:0];
  assign status_o.byte_ok = !rem[8];

  assign result = cmd_i.word_mode ? {byte_val, acc_r[StateW-1:ByteW]}
                                  : {{(StateW-ByteW){1'b0}}, byte_val};

  always_comb begin
    lcg_nxt = lcg_r;
    if (cmd_i.load_seed) begin
      lcg_nxt = seed_i;
    end else if (cmd_i.step) begin
      lcg_nxt = step_val;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (cmd_i.shift) begin
      acc_nxt = {byte_val, acc_r[StateW-1:ByteW]};
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd_i.out_load) begin
      out_nxt = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcg_r <= LcgReset;
    end else begin
      lcg_r <= lcg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    out_r <= out_nxt;
  end

  assign value_o = out_r;

endmodule

// File: rtl/core/lcgrw_ctrl.sv
// ---------------------------------------------------------------------------
// LCG rejection word generator - controller
// Command decode, draw sequencing and output beat handshake.
// ---------------------------------------------------------------------------
`include "lcg_rejection_word_generator_defines.svh"

module lcgrw_ctrl import lcgrw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  fsm_t       state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       word_mode_r, word_mode_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_take;
  logic       is_draw;
  logic       last_byte;
  logic       out_blocked;

  assign in_take     = in_valid && !in_stall;
  assign is_draw     = (in_cmd == CMD_BYTE) || (in_cmd == CMD_WORD);
  assign last_byte   = !word_mode_r || (cnt_r == 2'd3);
  assign out_blocked = out_valid_r && out_stall;

  // next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    word_mode_nxt = word_mode_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take && is_draw) begin
          state_nxt     = ST_RUN;
          cnt_nxt       = 2'd0;
          word_mode_nxt = (in_cmd == CMD_WORD);
        end
      end
      ST_RUN: begin
        if (cmd_o.out_load) begin
          state_nxt = ST_IDLE;
        end else if (cmd_o.shift) begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall        = 1'b1;
    cmd_o.load_seed = 1'b0;
    cmd_o.step      = 1'b0;
    cmd_o.shift     = 1'b0;
    cmd_o.out_load  = 1'b0;
    cmd_o.word_mode = word_mode_r;
    case (state_r)
      ST_IDLE: begin
        in_stall        = 1'b0;
        cmd_o.load_seed = in_valid && (in_cmd == CMD_SEED);
      end
      ST_RUN: begin
        // hold the final step until the output register can take the result
        cmd_o.step     = !(last_byte && status_i.byte_ok && out_blocked);
        cmd_o.shift    = cmd_o.step && status_i.byte_ok;
        cmd_o.out_load = cmd_o.shift && last_byte;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_o.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 2'd0;
      word_mode_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      word_mode_r <= word_mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `LRWG_ASSERT_NEVER(a_no_overwrite, cmd_o.out_load && out_blocked, "pending result overwritten")
  `LRWG_ASSERT(a_load_sets_valid, cmd_o.out_load |=> out_valid_r, "result beat not presented")
  `LRWG_ASSERT(a_draw_starts, (in_take && is_draw) |=> (state_r == ST_RUN), "draw did not start")
  `LRWG_ASSERT(a_byte_cnt, (state_r == ST_RUN && !word_mode_r) |-> (cnt_r == 2'd0), "byte count in byte mode")

endmodule

// File: rtl/core/lcg_rejection_word_generator.sv
// ---------------------------------------------------------------------------
// LCG rejection word generator - top level
// Seedable ANSI-style LCG producing rejection-sampled random bytes and words.
// ---------------------------------------------------------------------------
// Each accepted beat is a command: a seed load returns nothing; a byte draw
// steps the generator until a raw draw is accepted; a word draw does so until
// four bytes are accepted. A raw draw is rejected when its value is 256 mod
// 257, about 1 in 258. One generator step, a 32x32 multiply-add, runs per
// cycle and sets the rate, except while a final step is held as below.
// A new command is accepted in the cycle after the previous draw completes;
// a finished result waits in the output register without blocking a new
// command, but the next draw holds its final step until that result is
// taken. Unused command code 3 is accepted and ignored. State resets to 1.
// ---------------------------------------------------------------------------
module lcg_rejection_word_generator import lcgrw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_cmd,
  input  logic [StateW-1:0] in_seed_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [StateW-1:0] out_value
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  lcgrw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status_i  (dp_status),
    .cmd_o     (dp_cmd)
  );

  lcgrw_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_i    (dp_cmd),
    .seed_i   (in_seed_value),
    .status_o (dp_status),
    .value_o  (out_value)
  );

endmodule
